[hdl/utf8v_pkg.sv]
// Shared types, constants and helpers for the UTF-8 stream validator.
package utf8v_pkg;

   // Width of the code point being assembled
   localparam int unsigned CodeWidth    = 21;

   // Byte order mark
   localparam logic [7:0] MARK_BYTE0 = 8'hEF;
   localparam logic [7:0] MARK_BYTE1 = 8'hBB;
   localparam logic [7:0] MARK_BYTE2 = 8'hBF;

   // Sequence classes
   localparam logic [1:0] SEQ_TWO   = 2'd0;
   localparam logic [1:0] SEQ_THREE = 2'd1;
   localparam logic [1:0] SEQ_FOUR  = 2'd2;

   // Code point limits
   localparam logic [CodeWidth-1:0] MIN_TWO       = 21'h00080;
   localparam logic [CodeWidth-1:0] MIN_THREE     = 21'h00800;
   localparam logic [CodeWidth-1:0] MIN_FOUR      = 21'h10000;
   localparam logic [CodeWidth-1:0] SURR_LOW      = 21'h0D800;
   localparam logic [CodeWidth-1:0] SURR_HIGH     = 21'h0DFFF;
   localparam logic [CodeWidth-1:0] MAX_CODEPOINT = 21'h10FFFF;

   // Decoder and mark-check state carried from byte to byte
   typedef struct packed {
      logic [1:0]           pending_count;
      logic [CodeWidth-1:0] code_accum;
      logic [1:0]           seq_class;
      logic                 error_sticky;
      logic [1:0]           header_count;
      logic                 mark_match;
   } state_type;

   localparam state_type STATE_RESET = '{
      pending_count: 2'd0,
      code_accum:    '0,
      seq_class:     SEQ_TWO,
      error_sticky:  1'b0,
      header_count:  2'd0,
      mark_match:    1'b1
   };

   // Result of one byte
   typedef struct packed {
      logic no_error_yet;
      logic utf8_verdict;
      logic end_of_stream;
   } result_type;

   // Expected mark byte at a given stream position
   function automatic logic [7:0] mark_byte(input logic [1:0] pos);
      logic [7:0] val;
      case (pos)
         2'd0:    val = MARK_BYTE0;
         2'd1:    val = MARK_BYTE1;
         default: val = MARK_BYTE2;
      endcase
      return val;
   endfunction

   // Smallest code point allowed for a sequence class
   function automatic logic [CodeWidth-1:0] min_code(input logic [1:0] cls);
      logic [CodeWidth-1:0] val;
      case (cls)
         SEQ_TWO:   val = MIN_TWO;
         SEQ_THREE: val = MIN_THREE;
         default:   val = MIN_FOUR;
      endcase
      return val;
   endfunction

endpackage

[hdl/utf8_stream_validator.sv]
// Top level of the UTF-8 stream validator: request register, state and response register.
//
// Usage:
//   Request channel (req_*): one raw byte per request in req_tdata, with req_tlast
//   marking the final byte of a stream. A stream holds at least one byte.
//   Response channel (rsp_*): one response per request, in order. rsp_tdata bit 0
//   is the error-free-so-far flag, bit 1 the verdict (1 UTF-8, 0 Windows-1252),
//   valid only when rsp_tlast echoes the end of the stream.
//   A request accepted at a clock edge is loaded into the request register, then
//   moves into the response register once that register has room, and its
//   response is then shown on rsp_tvalid.
//   Throughput: one byte per cycle unless rsp_tready stalls, set by the single
//   per-byte step between the request and response registers, which also updates the state.
//   Reset: synchronous, active high; empties both registers and returns the
//   decoder and mark check to the start of a stream.
//   Stall: while rsp_tready is low the response holds, the pending request stays
//   in the request register, and req_tready falls once both are full.
module utf8_stream_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] no_error_yet, [1] utf8_verdict, [7:2] zero
   output logic       rsp_tlast    // end_of_stream
);
   import utf8v_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff;
   state_type  state_ff, state_in;
   result_type step_res;
   logic       advance;
   logic       req_take;

   // Move the held request into the response register when it has room
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take = req_tvalid && req_tready;

   utf8v_step u_step (
      .state_cur (state_ff),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .state_nxt (state_in),
      .result    (step_res)
   );

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_res_ff.utf8_verdict, out_res_ff.no_error_yet};
   assign rsp_tlast  = out_res_ff.end_of_stream;

   // The verdict is only ever raised on the last byte
   a_verdict_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1]) |-> rsp_tlast)
      else $error("verdict set on a byte that does not end the stream");

   // The last byte of a stream returns the state to its start value
   a_state_clear: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (state_ff == STATE_RESET))
      else $error("state not cleared after end of stream");

   // An error stays raised until the stream ends
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (state_ff.error_sticky && !(advance && in_last_ff)) |=> state_ff.error_sticky)
      else $error("error flag dropped inside a stream");

   // A response reporting no error never follows an erroring state in the same stream
   a_error_reported: assert property (@(posedge clock) disable iff (reset)
      (advance && state_ff.error_sticky) |=> (out_valid_ff && !out_res_ff.no_error_yet))
      else $error("error not reported on response");

endmodule

[hdl/utf8v_step.sv]
// Per-byte decode, mark check and verdict logic of the UTF-8 validator.
module utf8v_step (
   input  utf8v_pkg::state_type  state_cur,
   input  logic [7:0]            data_byte,
   input  logic                  last_byte,
   output utf8v_pkg::state_type  state_nxt,
   output utf8v_pkg::result_type result
);
   import utf8v_pkg::*;

   state_type            st;
   logic [CodeWidth-1:0] cp;
   logic                 has_mark;

   always_comb begin
      st = state_cur;
      cp = '0;

      // Track the byte order mark over the first three bytes
      if (st.header_count != 2'd3) begin
         if (data_byte != mark_byte(st.header_count)) begin
            st.mark_match = 1'b0;
         end
         st.header_count = st.header_count + 2'd1;
      end

      // Decode while no error has been seen
      if (!st.error_sticky) begin
         if (st.pending_count == 2'd0) begin
            if (data_byte[7] == 1'b0) begin
               // plain ASCII: nothing to do
            end else if (data_byte[7:5] == 3'b110) begin
               st.pending_count = 2'd1;
               st.code_accum    = {16'd0, data_byte[4:0]};
               st.seq_class     = SEQ_TWO;
            end else if (data_byte[7:4] == 4'b1110) begin
               st.pending_count = 2'd2;
               st.code_accum    = {17'd0, data_byte[3:0]};
               st.seq_class     = SEQ_THREE;
            end else if (data_byte[7:3] == 5'b11110) begin
               st.pending_count = 2'd3;
               st.code_accum    = {18'd0, data_byte[2:0]};
               st.seq_class     = SEQ_FOUR;
            end else begin
               st.error_sticky = 1'b1;
            end
         end else if (data_byte[7:6] != 2'b10) begin
            // bad continuation byte
            st.error_sticky  = 1'b1;
            st.pending_count = 2'd0;
         end else begin
            cp               = {st.code_accum[CodeWidth-7:0], data_byte[5:0]};
            st.code_accum    = cp;
            st.pending_count = st.pending_count - 2'd1;
            // Check overlong, surrogate and range at sequence end
            if (st.pending_count == 2'd0) begin
               if ((cp < min_code(st.seq_class)) ||
                   ((cp >= SURR_LOW) && (cp <= SURR_HIGH)) ||
                   (cp > MAX_CODEPOINT)) begin
                  st.error_sticky = 1'b1;
               end
            end
         end
      end

      // A stream may not end inside a sequence
      if (last_byte && (st.pending_count != 2'd0)) begin
         st.error_sticky = 1'b1;
      end

      has_mark = (st.header_count == 2'd3) && st.mark_match;

      result.no_error_yet  = !st.error_sticky;
      result.utf8_verdict  = last_byte && (has_mark || !st.error_sticky);
      result.end_of_stream = last_byte;

      // Start a fresh stream after the last byte
      state_nxt = last_byte ? STATE_RESET : st;
   end

endmodule

[verif/tb_utf8_stream_validator.sv]
// Self-checking stream testbench for the UTF-8 stream validator.
`timescale 1ns / 1ps

module tb_utf8_stream_validator;
   import utf8v_pkg::*;

   localparam int unsigned TargetItems = 750;
   localparam int unsigned DrainAfter  = 400;  // sender waits for all responses here
   localparam int unsigned HoldAt      = 200;  // response count that starts the long hold
   localparam int unsigned HoldCycles  = 60;
   localparam int unsigned ReportLimit = 10;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       drain;
   } stream_req_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] data_byte
   logic       req_tlast = 1'b0;    // last_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [0] no_error_yet, [1] utf8_verdict, [7:2] zero
   logic       rsp_tlast;           // end_of_stream

   stream_req_type pending_reqs[$];
   result_type  awaited_results[$];
   logic [7:0]  stream_buf[$];
   state_type   scan;

   int unsigned sent_count = 0;
   int unsigned rsp_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   logic        drain_placed = 1'b0;

   utf8_stream_validator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   // Advance the decoder and mark check by one byte and form its expected response
   function automatic result_type judge_byte(input logic [7:0] b, input logic last);
      result_type       res;
      logic [7:0]       want;
      logic [CodeWidth-1:0] cp;
      logic [CodeWidth-1:0] lower_bound;
      logic             mark_seen;
      if (scan.header_count != 2'd3) begin
         case (scan.header_count)
            2'd0:    want = MARK_BYTE0;
            2'd1:    want = MARK_BYTE1;
            default: want = MARK_BYTE2;
         endcase
         if (b != want) scan.mark_match = 1'b0;
         scan.header_count = scan.header_count + 2'd1;
      end
      // Decoding stops once an error is raised; only the mark check goes on
      if (!scan.error_sticky) begin
         if (scan.pending_count == 2'd0) begin
            if (b[7] == 1'b0) begin
               // plain ASCII
            end else if (b[7:5] == 3'b110) begin
               scan.pending_count = 2'd1;
               scan.code_accum = {16'd0, b[4:0]};
               scan.seq_class = SEQ_TWO;
            end else if (b[7:4] == 4'b1110) begin
               scan.pending_count = 2'd2;
               scan.code_accum = {17'd0, b[3:0]};
               scan.seq_class = SEQ_THREE;
            end else if (b[7:3] == 5'b11110) begin
               scan.pending_count = 2'd3;
               scan.code_accum = {18'd0, b[2:0]};
               scan.seq_class = SEQ_FOUR;
            end else begin
               scan.error_sticky = 1'b1;
            end
         end else if (b[7:6] != 2'b10) begin
            scan.error_sticky = 1'b1;
            scan.pending_count = 2'd0;
         end else begin
            cp = {scan.code_accum[14:0], b[5:0]};
            scan.code_accum = cp;
            scan.pending_count = scan.pending_count - 2'd1;
            if (scan.pending_count == 2'd0) begin
               case (scan.seq_class)
                  SEQ_TWO:   lower_bound = MIN_TWO;
                  SEQ_THREE: lower_bound = MIN_THREE;
                  default:   lower_bound = MIN_FOUR;
               endcase
               if (cp < lower_bound || (cp >= SURR_LOW && cp <= SURR_HIGH) ||
                   cp > MAX_CODEPOINT)
                  scan.error_sticky = 1'b1;
            end
         end
      end
      // A stream may not end inside a sequence
      if (last && scan.pending_count != 2'd0) scan.error_sticky = 1'b1;
      mark_seen = (scan.header_count == 2'd3) && scan.mark_match;
      res.no_error_yet  = !scan.error_sticky;
      res.utf8_verdict  = last && (mark_seen || !scan.error_sticky);
      res.end_of_stream = last;
      if (last) scan = STATE_RESET;
      return res;
   endfunction

   // Encode a code point in n bytes and keep only the first keep of them
   task automatic put_seq(input int unsigned cp, input int unsigned n, input int unsigned keep);
      logic [20:0] c;
      logic [7:0]  enc [0:3];
      c = cp[20:0];
      enc = '{8'h00, 8'h00, 8'h00, 8'h00};
      case (n)
         1: enc[0] = {1'b0, c[6:0]};
         2: begin
            enc[0] = {3'b110, c[10:6]};
            enc[1] = {2'b10, c[5:0]};
         end
         3: begin
            enc[0] = {4'b1110, c[15:12]};
            enc[1] = {2'b10, c[11:6]};
            enc[2] = {2'b10, c[5:0]};
         end
         default: begin
            enc[0] = {5'b11110, c[20:18]};
            enc[1] = {2'b10, c[17:12]};
            enc[2] = {2'b10, c[11:6]};
            enc[3] = {2'b10, c[5:0]};
         end
      endcase
      for (int i = 0; i < keep; i++) stream_buf.push_back(enc[i]);
   endtask

   // Append one piece of text: mostly well-formed characters, some broken forms
   task automatic add_token();
      int unsigned pick;
      int unsigned cp;
      int unsigned n;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         put_seq($urandom_range(0, 127), 1, 1);
      end else if (pick < 50) begin
         put_seq($urandom_range(128, 2047), 2, 2);
      end else if (pick < 62) begin
         cp = $urandom_range(32'h800, 32'hFFFF);
         if (cp >= 32'hD800 && cp <= 32'hDFFF) cp = cp - 32'h800;
         put_seq(cp, 3, 3);
      end else if (pick < 72) begin
         put_seq($urandom_range(32'h10000, 32'h10FFFF), 4, 4);
      end else if (pick < 76) begin
         // overlong form
         n = $urandom_range(2, 4);
         cp = $urandom_range(0, (n == 2) ? 127 : (n == 3) ? 2047 : 65535);
         put_seq(cp, n, n);
      end else if (pick < 79) begin
         put_seq($urandom_range(32'hD800, 32'hDFFF), 3, 3);
      end else if (pick < 82) begin
         put_seq($urandom_range(32'h110000, 32'h1FFFFF), 4, 4);
      end else if (pick < 88) begin
         // sequence cut short
         n = $urandom_range(2, 4);
         put_seq($urandom_range(0, 32'h1FFFFF), n, $urandom_range(1, n - 1));
      end else if (pick < 92) begin
         stream_buf.push_back({2'b10, 6'($urandom_range(0, 63))});
      end else begin
         stream_buf.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // Move the assembled stream into the request queue, marking its final byte
   task automatic flush_stream(input logic drain);
      for (int i = 0; i < stream_buf.size(); i++)
         pending_reqs.push_back('{data: stream_buf[i],
                                  last: (i == stream_buf.size() - 1),
                                  drain: (i == 0) && drain});
      stream_buf.delete();
   endtask

   task automatic build_random_stream(input logic drain);
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
         // short stream of raw bytes
         repeat ($urandom_range(1, 3)) stream_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
         if (pick < 7) begin
            stream_buf.push_back(MARK_BYTE0);
            stream_buf.push_back(MARK_BYTE1);
            stream_buf.push_back(MARK_BYTE2);
         end else if (pick < 9) begin
            // partial mark
            stream_buf.push_back(MARK_BYTE0);
            if (pick == 8) stream_buf.push_back(MARK_BYTE1);
         end
         repeat ($urandom_range(1, 6)) add_token();
      end
      flush_stream(drain);
   endtask

   task automatic check_bits(input string what, input int unsigned want, input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= ReportLimit)
            $display("response %0d: %s expected %0h got %0h", rsp_count, what, want, got);
      end
   endtask

   // Request driver
   always @(posedge clock) begin
      stream_req_type nxt;
      logic        show;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'h00;
         req_tlast  <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_results.push_back(judge_byte(req_tdata, req_tlast));
            sent_count++;
         end
         if (!req_tvalid || req_tready) begin
            show = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].drain && awaited_results.size() != 0)) begin
               nxt = pending_reqs.pop_front();
               req_tdata <= nxt.data;
               req_tlast <= nxt.last;
               show = 1'b1;
               // idle-free stretch every third block of requests
               gap_left = ((sent_count / 120) % 3 == 1) ? 0 : $urandom_range(0, 7);
            end
            req_tvalid <= show;
         end
      end
   end

   // Response monitor and receiver stalls
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= ReportLimit)
                  $display("response %0d: unexpected, data %0h last %0b",
                           rsp_count, rsp_tdata, rsp_tlast);
            end else begin
               want = awaited_results.pop_front();
               check_bits("no_error_yet", 32'(want.no_error_yet), 32'(rsp_tdata[0]));
               check_bits("utf8_verdict", 32'(want.utf8_verdict), 32'(rsp_tdata[1]));
               check_bits("tdata padding", 32'd0, 32'(rsp_tdata[7:2]));
               check_bits("end_of_stream", 32'(want.end_of_stream), 32'(rsp_tlast));
            end
            rsp_count++;
            if (rsp_count == HoldAt) hold_left = HoldCycles;
            else stall_left = ((rsp_count / 90) % 3 == 2) ? 0 : $urandom_range(0, 7);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      scan = STATE_RESET;
      // Mark followed by valid text, then mark followed by an invalid lead
      stream_buf = '{8'hEF, 8'hBB, 8'hBF, 8'h41};
      flush_stream(1'b0);
      stream_buf = '{8'hEF, 8'hBB, 8'hBF, 8'hFF};
      flush_stream(1'b0);
      // Short stream that ends inside a sequence
      stream_buf = '{8'hEF, 8'hBB};
      flush_stream(1'b0);
      stream_buf = '{8'h00};
      flush_stream(1'b0);
      // Overlong, surrogate, above the top code point
      stream_buf = '{8'hC0, 8'h80};
      flush_stream(1'b0);
      stream_buf = '{8'hED, 8'hA0, 8'h80};
      flush_stream(1'b0);
      stream_buf = '{8'hF4, 8'h90, 8'h80, 8'h80};
      flush_stream(1'b0);
      // Valid four-byte form, then a bad continuation
      stream_buf = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'h7F};
      flush_stream(1'b0);
      stream_buf = '{8'hC3, 8'h41};
      flush_stream(1'b0);

      while (pending_reqs.size() < TargetItems) begin
         build_random_stream(!drain_placed && pending_reqs.size() >= DrainAfter);
         if (pending_reqs.size() >= DrainAfter) drain_placed = 1'b1;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Sample settled values away from the driving edge
      while (pending_reqs.size() != 0 || req_tvalid) @(negedge clock);
      while (awaited_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatch_count == 0)
         $display("tb_utf8_stream_validator OK");
      else
         $display("tb_utf8_stream_validator NOT OK");
      $finish;
   end

   initial begin
      #(3_000_000);
      $display("tb_utf8_stream_validator NOT OK");
      $finish;
   end

endmodule
